@@ rtl/b2da_pkg.sv @@
`timescale 1ns / 1ps

package b2da_pkg;

   localparam int INPUT_WIDTH = 32;
   // decimal digits needed for 2^INPUT_WIDTH - 1: ceil(INPUT_WIDTH * log10(2))
   localparam int NUM_DIGITS  = (INPUT_WIDTH * 30103 + 99999) / 100000;
   localparam int BIT_CNT_W   = $clog2(INPUT_WIDTH);
   localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

   localparam logic [5:0] ASCII_ZERO = 6'd48;

   typedef logic [3:0] bcd_digit_type;

   typedef struct packed {
      logic clear;
      logic bin_shift;
      logic dig_shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

@@ rtl/binary_to_decimal_ascii.sv @@
`timescale 1ns / 1ps

// binary_to_decimal_ascii
// Converts an unsigned binary value to decimal ASCII digits, most significant
// digit first, leading zeros dropped (zero gives a single '0').
// Input: an item is taken when start is high and busy is low; req_value is
// sampled at that edge. busy stays high until the last digit has gone out.
// Output: each digit is on rsp_digit_char for one cycle with rsp_strobe high;
// rsp_last_digit marks the least significant digit. The receiver cannot
// stall; digits come in consecutive cycles.
// Operation: a row of NUM_DIGITS BCD cells (10 at 32 bits) takes one input
// bit per cycle until all INPUT_WIDTH bits are in. The row then shifts one
// digit per cycle toward the top cell: leading zeros are dropped one a cycle,
// a settling step follows, then one digit is emitted per cycle.
// Reset (synchronous, active high) returns the controller to idle; any item
// in progress is dropped.
module binary_to_decimal_ascii
   import b2da_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [INPUT_WIDTH-1:0] req_value,
   output logic                   rsp_strobe,
   output logic [5:0]             rsp_digit_char,
   output logic                   rsp_last_digit
);

   state_type              state_ff, state_in;
   logic [INPUT_WIDTH-1:0] value_ff, value_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   cell_ctrl_type          ctrl;

   logic          carry [NUM_DIGITS+1];
   bcd_digit_type digit [NUM_DIGITS+1];
   bcd_digit_type top_digit;

   assign carry[0] = value_ff[INPUT_WIDTH-1];
   assign digit[0] = '0;
   assign top_digit = digit[NUM_DIGITS];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      b2da_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .carry_in  (carry[i]),
         .carry_out (carry[i+1]),
         .digit_in  (digit[i]),
         .digit_out (digit[i+1])
      );
   end

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      ctrl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in   = req_value;
               bit_cnt_in = '0;
               dig_cnt_in = DIG_CNT_W'(NUM_DIGITS);
               ctrl.clear = 1'b1;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctrl.bin_shift = 1'b1;
            value_in       = {value_ff[INPUT_WIDTH-2:0], 1'b0};
            bit_cnt_in     = BIT_CNT_W'(bit_cnt_ff + 1'b1);
            if (bit_cnt_ff == BIT_CNT_W'(INPUT_WIDTH - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && dig_cnt_ff != DIG_CNT_W'(1)) begin
               ctrl.dig_shift = 1'b1;
               dig_cnt_in     = DIG_CNT_W'(dig_cnt_ff - 1'b1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            ctrl.dig_shift = 1'b1;
            dig_cnt_in     = DIG_CNT_W'(dig_cnt_ff - 1'b1);
            if (dig_cnt_ff == DIG_CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = (state_ff == ST_EMIT);
   assign rsp_digit_char = 6'(ASCII_ZERO + {2'b00, top_digit});
   assign rsp_last_digit = rsp_strobe && (dig_cnt_ff == DIG_CNT_W'(1));

`ifndef SYNTH
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_digit |=> !busy)
      else $error("busy still high after last digit");

   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) && !rsp_last_digit |-> rsp_digit_char != ASCII_ZERO)
      else $error("leading zero emitted");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT |-> !carry[NUM_DIGITS])
      else $error("BCD row overflow");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> top_digit <= 4'd9)
      else $error("digit out of range");
`endif

endmodule

@@ rtl/b2da_cell.sv @@
`timescale 1ns / 1ps

module b2da_cell
   import b2da_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          carry_in,
   output logic          carry_out,
   input  bcd_digit_type digit_in,
   output bcd_digit_type digit_out
);

   bcd_digit_type digit_ff;
   bcd_digit_type digit_in_next;
   bcd_digit_type adj;

   // add-3 correction before the shift
   assign adj       = (digit_ff > 4'd4) ? 4'(digit_ff + 4'd3) : digit_ff;
   assign carry_out = adj[3];
   assign digit_out = digit_ff;

   always_comb begin
      digit_in_next = digit_ff;
      if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.bin_shift) begin
         digit_in_next = {adj[2:0], carry_in};
      end else if (ctrl.dig_shift) begin
         digit_in_next = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule
